[hw/rtl/triangle_circumcircle_top_defines.svh]
// Assertion macros for the triangle circumcircle block.
// Used by triangle_circumcircle_top; expects clk_i and rst_ni in scope.
`ifndef TRIANGLE_CIRCUMCIRCLE_TOP_DEFINES_SVH
`define TRIANGLE_CIRCUMCIRCLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ccr assertion failed");
`define CCR_ASSERT_NEXT(label, ante, cons) \
  `CCR_ASSERT(label, (ante) |=> (cons))
`else
`define CCR_ASSERT(label, prop)
`define CCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/ccr_pkg.sv]
// Shared widths, types and step functions of the circumcircle pipeline.
// No dependencies; imported by every ccr module and the top level.
`default_nettype none

package ccr_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 48;
  localparam int RAD_BITS   = 47;

  localparam int DIFF_W = COORD_BITS + 1;          // edge vector component
  localparam int PROD_W = 2 * DIFF_W;              // product of two components
  localparam int DET_W  = PROD_W + 1;              // cross product
  localparam int SQ_W   = 2 * COORD_BITS + 1;      // squared edge length
  localparam int NUM_W  = SQ_W + DIFF_W + 1;       // center numerator
  localparam int SNUM_W = NUM_W + FRAC_BITS;       // numerator in Q.FRAC
  localparam int MAG_W  = SNUM_W - 1;              // numerator magnitude
  localparam int DIV_W  = DET_W - 1;               // |2d|
  localparam int Q_W    = MAG_W + 1;               // signed offset
  localparam int CEN_W  = Q_W + 1;                 // a + offset before clamp
  localparam int LO_W   = (RAD_BITS + 1) / 2;
  localparam int HI_W   = RAD_BITS - LO_W;
  localparam int SQX_W  = 2 * RAD_BITS;
  localparam int SUM_W  = SQX_W + 1;
  localparam int ROOT_W = RAD_BITS + 1;
  localparam int T_W    = SUM_W + 1;

  localparam int FRONT_DEPTH = 6;
  localparam int POST_DEPTH  = 5;

  localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [RAD_BITS-1:0] RAD_MAX = {RAD_BITS{1'b1}};

  typedef enum logic [1:0] {
    ORIENT_CCW  = 2'd0,
    ORIENT_CW   = 2'd1,
    ORIENT_COLL = 2'd2
  } orient_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic                         d_neg;
    logic                         coll;
  } tri_side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MAG_W-1:0] qn;   // numerator bits shift out the top, quotient in the bottom
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    tri_side_t        side;
    logic [DIV_W-1:0] dv;
    div_lane_t        lx;
    div_lane_t        ly;
  } div_stage_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
    logic                       csat;
    logic                       rbig;
    logic                       d_neg;
    logic                       coll;
  } res_side_t;

  typedef struct packed {
    res_side_t         side;
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

  // one restoring division step
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] dv);
    logic [DIV_W:0] r2;
    logic [DIV_W:0] diff;
    logic           ge;
    div_lane_t      o;
    r2    = {l.rem, l.qn[MAG_W-1]};
    diff  = r2 - {1'b0, dv};
    ge    = r2 >= {1'b0, dv};
    o.rem = ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
    o.qn  = {l.qn[MAG_W-2:0], ge};
    o.neg = l.neg;
    return o;
  endfunction

  // one digit of the integer square root, result bit bit_i
  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t st, int unsigned bit_i);
    logic [T_W-1:0] t;
    logic [T_W-1:0] r_ext;
    logic [T_W-1:0] diff;
    sqrt_stage_t    o;
    t     = (T_W'(st.root) << (bit_i + 1)) + (T_W'(1) << (2 * bit_i));
    r_ext = T_W'(st.rem);
    diff  = r_ext - t;
    o     = st;
    if (r_ext >= t) begin
      o.rem  = diff[SUM_W-1:0];
      o.root = st.root | (ROOT_W'(1) << bit_i);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ccr_front.sv]
// Front stages: edge vectors, cross product, center numerators, divisor.
// Depends on ccr_pkg; feeds ccr_div.
`default_nettype none

module ccr_front import ccr_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  output logic                         valid_o,
  output div_stage_t                   stage_o
);

  logic [FRONT_DEPTH-1:0] vld_q;

  logic signed [COORD_BITS-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [DIFF_W-1:0] abx1_q, aby1_q, acx1_q, acy1_q;
  logic signed [DIFF_W-1:0] abx2_q, aby2_q, acx2_q, acy2_q;
  logic signed [DIFF_W-1:0] abx3_q, aby3_q, acx3_q, acy3_q;
  logic signed [PROD_W-1:0] pd1_q, pd2_q, sq_abx_q, sq_aby_q, sq_acx_q, sq_acy_q;
  logic signed [DET_W-1:0]  det3_q;
  logic [SQ_W-1:0]          ab2_q, ac2_q;
  logic signed [NUM_W-2:0]  m1_q, m2_q, m3_q, m4_q;
  logic [DIV_W-1:0]         dv4_q, dv5_q;
  tri_side_t                side4_q, side5_q;
  logic signed [NUM_W-1:0]  nx5_q, ny5_q;
  logic signed [DET_W-1:0]  dabs;
  logic signed [SNUM_W-1:0] shx, shy, magx, magy;
  div_stage_t               stage_d, stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRONT_DEPTH-2:0], valid_i};
    end
  end

  assign dabs = det3_q[DET_W-1] ? -det3_q : det3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= a_x_i;
      ay1_q  <= a_y_i;
      abx1_q <= {b_x_i[COORD_BITS-1], b_x_i} - {a_x_i[COORD_BITS-1], a_x_i};
      aby1_q <= {b_y_i[COORD_BITS-1], b_y_i} - {a_y_i[COORD_BITS-1], a_y_i};
      acx1_q <= {c_x_i[COORD_BITS-1], c_x_i} - {a_x_i[COORD_BITS-1], a_x_i};
      acy1_q <= {c_y_i[COORD_BITS-1], c_y_i} - {a_y_i[COORD_BITS-1], a_y_i};

      pd1_q    <= abx1_q * acy1_q;
      pd2_q    <= aby1_q * acx1_q;
      sq_abx_q <= abx1_q * abx1_q;
      sq_aby_q <= aby1_q * aby1_q;
      sq_acx_q <= acx1_q * acx1_q;
      sq_acy_q <= acy1_q * acy1_q;
      {ax2_q, ay2_q} <= {ax1_q, ay1_q};
      {abx2_q, aby2_q, acx2_q, acy2_q} <= {abx1_q, aby1_q, acx1_q, acy1_q};

      det3_q <= DET_W'(pd1_q) - DET_W'(pd2_q);
      ab2_q  <= SQ_W'(sq_abx_q) + SQ_W'(sq_aby_q);
      ac2_q  <= SQ_W'(sq_acx_q) + SQ_W'(sq_acy_q);
      {ax3_q, ay3_q} <= {ax2_q, ay2_q};
      {abx3_q, aby3_q, acx3_q, acy3_q} <= {abx2_q, aby2_q, acx2_q, acy2_q};

      m1_q <= $signed({1'b0, ab2_q}) * acy3_q;
      m2_q <= $signed({1'b0, ac2_q}) * aby3_q;
      m3_q <= $signed({1'b0, ac2_q}) * abx3_q;
      m4_q <= $signed({1'b0, ab2_q}) * acx3_q;
      dv4_q         <= {dabs[DIV_W-2:0], 1'b0};
      side4_q.a_x   <= ax3_q;
      side4_q.a_y   <= ay3_q;
      side4_q.d_neg <= det3_q[DET_W-1];
      side4_q.coll  <= (det3_q == '0);

      nx5_q   <= NUM_W'(m1_q) - NUM_W'(m2_q);
      ny5_q   <= NUM_W'(m3_q) - NUM_W'(m4_q);
      dv5_q   <= dv4_q;
      side5_q <= side4_q;

      stage_q <= stage_d;
    end
  end

  always_comb begin
    shx  = SNUM_W'(nx5_q) <<< FRAC_BITS;
    shy  = SNUM_W'(ny5_q) <<< FRAC_BITS;
    magx = shx[SNUM_W-1] ? -shx : shx;
    magy = shy[SNUM_W-1] ? -shy : shy;
    stage_d.side   = side5_q;
    stage_d.dv     = dv5_q;
    stage_d.lx.rem = '0;
    stage_d.lx.qn  = magx[MAG_W-1:0];
    stage_d.lx.neg = nx5_q[NUM_W-1] ^ side5_q.d_neg;
    stage_d.ly.rem = '0;
    stage_d.ly.qn  = magy[MAG_W-1:0];
    stage_d.ly.neg = ny5_q[NUM_W-1] ^ side5_q.d_neg;
  end

  assign valid_o = vld_q[FRONT_DEPTH-1];
  assign stage_o = stage_q;

endmodule

`default_nettype wire

[hw/rtl/ccr_div.sv]
// Bit-per-stage restoring divider, x and y lanes sharing the divisor |2d|.
// Depends on ccr_pkg; fed by ccr_front, feeds ccr_post.
`default_nettype none

module ccr_div import ccr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_stage_t stage_i,
  output logic       valid_o,
  output div_stage_t stage_o
);

  logic [MAG_W-1:0] vld_q;
  div_stage_t       st_q [MAG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[MAG_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_step
    div_stage_t prev;
    if (k == 0) begin : g_first
      assign prev = stage_i;
    end else begin : g_rest
      assign prev = st_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k].side <= prev.side;
        st_q[k].dv   <= prev.dv;
        st_q[k].lx   <= div_step(prev.lx, prev.dv);
        st_q[k].ly   <= div_step(prev.ly, prev.dv);
      end
    end
  end

  assign valid_o = vld_q[MAG_W-1];
  assign stage_o = st_q[MAG_W-1];

endmodule

`default_nettype wire

[hw/rtl/ccr_post.sv]
// Floor rounding, center add and clamp, squared offset length.
// Depends on ccr_pkg; fed by ccr_div, feeds ccr_sqrt.
`default_nettype none

module ccr_post import ccr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_stage_t       stage_i,
  output logic             valid_o,
  output res_side_t        side_o,
  output logic [SUM_W-1:0] s_o
);

  // truncated quotient to floor: negative with remainder gives -(q+1) = ~q
  function automatic logic signed [Q_W-1:0] fix_sign(div_lane_t l);
    logic [Q_W-1:0] q;
    logic           rnz;
    q   = {1'b0, l.qn};
    rnz = |l.rem;
    if (!l.neg) begin
      return q;
    end else if (rnz) begin
      return ~q;
    end else begin
      return -q;
    end
  endfunction

  function automatic logic [OUT_BITS:0] clamp_c(logic signed [CEN_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    logic [OUT_BITS:0] r;
    hi_ones  = &v[CEN_W-1:OUT_BITS-1];
    hi_zeros = ~|v[CEN_W-1:OUT_BITS-1];
    if (hi_ones || hi_zeros) begin
      r = {1'b0, v[OUT_BITS-1:0]};
    end else if (v[CEN_W-1]) begin
      r = {1'b1, OUT_MIN};
    end else begin
      r = {1'b1, OUT_MAX};
    end
    return r;
  endfunction

  logic [POST_DEPTH-1:0]  vld_q;
  tri_side_t              side1_q;
  logic signed [Q_W-1:0]  ux1_q, uy1_q;
  res_side_t              side2_q, side3_q, side4_q, side5_q;
  logic [RAD_BITS-1:0]    mx2_q, my2_q;
  logic [2*HI_W-1:0]      hhx3_q, hhy3_q;
  logic [HI_W+LO_W-1:0]   hlx3_q, hly3_q;
  logic [2*LO_W-1:0]      llx3_q, lly3_q;
  logic [SQX_W-1:0]       sx4_q, sy4_q;
  logic [SUM_W-1:0]       s5_q;

  logic signed [CEN_W-1:0] cx_sum, cy_sum;
  logic [OUT_BITS:0]       cx_cl, cy_cl;
  logic signed [Q_W-1:0]   mx, my;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[POST_DEPTH-2:0], valid_i};
    end
  end

  always_comb begin
    cx_sum = (CEN_W'($signed(side1_q.a_x)) <<< FRAC_BITS) + CEN_W'(ux1_q);
    cy_sum = (CEN_W'($signed(side1_q.a_y)) <<< FRAC_BITS) + CEN_W'(uy1_q);
    cx_cl  = clamp_c(cx_sum);
    cy_cl  = clamp_c(cy_sum);
    mx     = ux1_q[Q_W-1] ? -ux1_q : ux1_q;
    my     = uy1_q[Q_W-1] ? -uy1_q : uy1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux1_q   <= fix_sign(stage_i.lx);
      uy1_q   <= fix_sign(stage_i.ly);
      side1_q <= stage_i.side;

      side2_q.cx    <= cx_cl[OUT_BITS-1:0];
      side2_q.cy    <= cy_cl[OUT_BITS-1:0];
      side2_q.csat  <= cx_cl[OUT_BITS] | cy_cl[OUT_BITS];
      side2_q.rbig  <= (|mx[MAG_W-1:RAD_BITS]) | (|my[MAG_W-1:RAD_BITS]);
      side2_q.d_neg <= side1_q.d_neg;
      side2_q.coll  <= side1_q.coll;
      mx2_q <= mx[RAD_BITS-1:0];
      my2_q <= my[RAD_BITS-1:0];

      // square split into high and low halves
      hhx3_q <= mx2_q[RAD_BITS-1:LO_W] * mx2_q[RAD_BITS-1:LO_W];
      hlx3_q <= mx2_q[RAD_BITS-1:LO_W] * mx2_q[LO_W-1:0];
      llx3_q <= mx2_q[LO_W-1:0] * mx2_q[LO_W-1:0];
      hhy3_q <= my2_q[RAD_BITS-1:LO_W] * my2_q[RAD_BITS-1:LO_W];
      hly3_q <= my2_q[RAD_BITS-1:LO_W] * my2_q[LO_W-1:0];
      lly3_q <= my2_q[LO_W-1:0] * my2_q[LO_W-1:0];
      side3_q <= side2_q;

      sx4_q <= (SQX_W'(hhx3_q) << (2 * LO_W)) + (SQX_W'(hlx3_q) << (LO_W + 1))
               + SQX_W'(llx3_q);
      sy4_q <= (SQX_W'(hhy3_q) << (2 * LO_W)) + (SQX_W'(hly3_q) << (LO_W + 1))
               + SQX_W'(lly3_q);
      side4_q <= side3_q;

      s5_q    <= SUM_W'(sx4_q) + SUM_W'(sy4_q);
      side5_q <= side4_q;
    end
  end

  assign valid_o = vld_q[POST_DEPTH-1];
  assign side_o  = side5_q;
  assign s_o     = s5_q;

endmodule

`default_nettype wire

[hw/rtl/ccr_sqrt.sv]
// Digit-by-digit integer square root, one result bit per stage.
// Depends on ccr_pkg; fed by ccr_post, feeds the output register.
`default_nettype none

module ccr_sqrt import ccr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  res_side_t        side_i,
  input  logic [SUM_W-1:0] s_i,
  output logic             valid_o,
  output sqrt_stage_t      stage_o
);

  logic [ROOT_W-1:0] vld_q;
  sqrt_stage_t       st_q [ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    sqrt_stage_t prev;
    if (k == 0) begin : g_first
      assign prev.side = side_i;
      assign prev.rem  = s_i;
      assign prev.root = '0;
    end else begin : g_rest
      assign prev = st_q[k-1];
    end

    // most significant root bit first
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= sqrt_step(prev, ROOT_W - 1 - k);
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign stage_o = st_q[ROOT_W-1];

endmodule

`default_nettype wire

[hw/rtl/triangle_circumcircle_top.sv]
// Triangle circumcircle: center and radius of the circle through three vertices.
// Input channel: in_valid_i / in_stall_o with the six vertex coordinates; one
//   word is taken at each edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with center, radius, orientation,
//   collinear and saturated flags; one result word per input word, in order.
// Throughput: one word per cycle while in_stall_o is low. The pipeline holds the
//   58 one-bit stages of the divider and the 48 one-bit stages of the square
//   root, plus 11 arithmetic stages and the output register.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output register.
// When the receiver stalls, the result holds in the output register and the
//   pipeline keeps moving until its last stage is full; only then does
//   in_stall_o rise. Nothing is dropped or repeated.
// Depends on ccr_pkg, ccr_front, ccr_div, ccr_post, ccr_sqrt and the defines header.
`default_nettype none
`include "triangle_circumcircle_top_defines.svh"

module triangle_circumcircle_top import ccr_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_BITS-1:0]   center_x_o,
  output logic signed [OUT_BITS-1:0]   center_y_o,
  output logic [RAD_BITS-1:0]          radius_o,
  output logic [1:0]                   orientation_o,
  output logic                         collinear_o,
  output logic                         saturated_o
);

  logic        adv, out_take;
  logic        fr_valid, dv_valid, po_valid, sq_valid;
  div_stage_t  fr_stage, dv_stage;
  res_side_t   po_side;
  logic [SUM_W-1:0] po_s;
  sqrt_stage_t sq_stage;

  logic                       out_valid_q;
  logic signed [OUT_BITS-1:0] cx_q, cy_q, cx_d, cy_d;
  logic [RAD_BITS-1:0]        rad_q, rad_d;
  orient_e                    orient_q, orient_d;
  logic                       coll_q, sat_q, coll_d, sat_d;

  assign out_take   = !out_valid_q || !out_stall_i;
  assign adv        = out_take || !sq_valid;
  assign in_stall_o = !adv;

  ccr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .valid_o (fr_valid),
    .stage_o (fr_stage)
  );

  ccr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_valid),
    .stage_i (fr_stage),
    .valid_o (dv_valid),
    .stage_o (dv_stage)
  );

  ccr_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dv_valid),
    .stage_i (dv_stage),
    .valid_o (po_valid),
    .side_o  (po_side),
    .s_o     (po_s)
  );

  ccr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (po_valid),
    .side_i  (po_side),
    .s_i     (po_s),
    .valid_o (sq_valid),
    .stage_o (sq_stage)
  );

  always_comb begin
    cx_d     = sq_stage.side.cx;
    cy_d     = sq_stage.side.cy;
    rad_d    = (sq_stage.side.rbig || sq_stage.root[ROOT_W-1]) ?
               RAD_MAX : sq_stage.root[RAD_BITS-1:0];
    sat_d    = sq_stage.side.csat | sq_stage.side.rbig | sq_stage.root[ROOT_W-1];
    coll_d   = 1'b0;
    orient_d = sq_stage.side.d_neg ? ORIENT_CW : ORIENT_CCW;
    // degenerate triangle: center, radius and saturated flag are zero, orientation is collinear
    if (sq_stage.side.coll) begin
      cx_d     = '0;
      cy_d     = '0;
      rad_d    = '0;
      sat_d    = 1'b0;
      coll_d   = 1'b1;
      orient_d = ORIENT_COLL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && sq_valid) begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      rad_q    <= rad_d;
      sat_q    <= sat_d;
      coll_q   <= coll_d;
      orient_q <= orient_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;
  assign radius_o      = rad_q;
  assign orientation_o = orient_q;
  assign collinear_o   = coll_q;
  assign saturated_o   = sat_q;

  `CCR_ASSERT(a_coll_zero, out_valid_o && collinear_o |-> center_x_o == '0 && center_y_o == '0 && radius_o == '0 && !saturated_o)
  `CCR_ASSERT(a_orient_coll, out_valid_o |-> ((orientation_o == ORIENT_COLL) == collinear_o))
  `CCR_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i && sq_valid)
  `CCR_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !sq_valid, !out_valid_o)

endmodule

`default_nettype wire
